>>> rtl/fsrt_pkg.sv
// ---------------------------------------------------------------------------
// fsrt_pkg: shared types and constants of the record slot table
// Table size, field widths, opcodes, status codes and the command and status
// bundles exchanged between the controller and the datapath.
// ---------------------------------------------------------------------------
package fsrt_pkg;

   localparam int MAX_ENTRIES = 2048;
   localparam int SLOT_W      = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

   localparam int OP_W       = 3;
   localparam int POS_W      = 12;
   localparam int STATUS_W   = 2;
   localparam int PAGE_W     = 16;
   localparam int ECOUNT_W   = 13;
   localparam int STRIDE_W   = 9;
   localparam int PROD_W     = SLOT_W + STRIDE_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0]  COUNT_MAX = COUNT_W'(MAX_ENTRIES);
   localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(MAX_ENTRIES - 1);

   localparam logic [PAGE_W-1:0]   FIRST_PAGE_RST = 16'd16;
   localparam logic [STRIDE_W-1:0] STRIDE_RST     = 9'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PAGE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE     = 1'd1;

   // opcodes
   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_GET    = 3'd2;
   localparam logic [OP_W-1:0] OP_SWAP   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   // index counter commands
   localparam logic [1:0] IX_HOLD = 2'd0;
   localparam logic [1:0] IX_ZERO = 2'd1;
   localparam logic [1:0] IX_INC  = 2'd2;
   localparam logic [1:0] IX_PA   = 2'd3;

   // entry count commands
   localparam logic [1:0] CN_HOLD = 2'd0;
   localparam logic [1:0] CN_INC  = 2'd1;
   localparam logic [1:0] CN_DEC  = 2'd2;
   localparam logic [1:0] CN_CLR  = 2'd3;

   // slot list read address select
   localparam logic [1:0] LR_PA  = 2'd0;
   localparam logic [1:0] LR_PB  = 2'd1;
   localparam logic [1:0] LR_IDX = 2'd2;

   // slot list write commands (shift writes come from the pending flag)
   localparam logic [1:0] LW_NONE   = 2'd0;
   localparam logic [1:0] LW_ADD    = 2'd1;
   localparam logic [1:0] LW_SWAP_A = 2'd2;
   localparam logic [1:0] LW_SWAP_B = 2'd3;

   // used map write commands
   localparam logic [1:0] UW_NONE  = 2'd0;
   localparam logic [1:0] UW_SWEEP = 2'd1;
   localparam logic [1:0] UW_SET   = 2'd2;
   localparam logic [1:0] UW_FREE  = 2'd3;

   // result register commands
   localparam logic [2:0] RES_HOLD  = 3'd0;
   localparam logic [2:0] RES_ZERO  = 3'd1;
   localparam logic [2:0] RES_FULL  = 3'd2;
   localparam logic [2:0] RES_RANGE = 3'd3;
   localparam logic [2:0] RES_SCAN  = 3'd4;
   localparam logic [2:0] RES_LIST  = 3'd5;

   typedef struct packed {
      logic       capture;
      logic [1:0] idx_op;
      logic [1:0] cnt_op;
      logic [1:0] lr_sel;
      logic [1:0] lw_op;
      logic [1:0] uw_op;
      logic       used_rd;
      logic       shift_rd;
      logic       tmp_ld;
      logic [2:0] res_op;
      logic       rsp_ld;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            pa_bad;
      logic            pb_bad;
      logic            used_free;
      logic            idx_last;
      logic            idx_le_count;
   } dp_stat_type;

endpackage

>>> rtl/fsrt_dpath.sv
// ---------------------------------------------------------------------------
// fsrt_dpath: datapath of the record slot table
// Slot list and used map memories, entry count, index counter, configuration
// registers, page arithmetic and the result registers.
// ---------------------------------------------------------------------------
module fsrt_dpath import fsrt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [POS_W-1:0]      req_pos_a,
   input  logic [POS_W-1:0]      req_pos_b,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [PAGE_W-1:0]     rsp_page,
   output logic [ECOUNT_W-1:0]   rsp_entry_count
);

   logic [PAGE_W-1:0]   cfg_first_ff;
   logic [STRIDE_W-1:0] cfg_stride_ff;

   logic [OP_W-1:0]     op_ff;
   logic [POS_W-1:0]    pa_ff;
   logic [POS_W-1:0]    pb_ff;

   logic [COUNT_W-1:0]  idx_ff, idx_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic                used_map_ff [MAX_ENTRIES];
   logic                used_rdata_ff;
   logic [SLOT_W-1:0]   scan_addr_ff;
   logic                used_we;
   logic [SLOT_W-1:0]   used_waddr;
   logic                used_wdata;

   logic [SLOT_W-1:0]   slot_list_ff [MAX_ENTRIES];
   logic [SLOT_W-1:0]   list_rdata_ff;
   logic [SLOT_W-1:0]   list_addr_ff;
   logic [SLOT_W-1:0]   list_raddr;
   logic                list_we;
   logic [SLOT_W-1:0]   list_waddr;
   logic [SLOT_W-1:0]   list_wdata;

   logic                pend_ff;
   logic [SLOT_W-1:0]   tmp_ff;

   logic [SLOT_W-1:0]   page_slot;
   logic [PROD_W-1:0]   page_prod;
   logic [PAGE_W-1:0]   page_calc;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [PAGE_W-1:0]   res_page_ff, res_page_in;

   logic [STATUS_W-1:0] rsp_status_ff;
   logic [PAGE_W-1:0]   rsp_page_ff;
   logic [ECOUNT_W-1:0] rsp_entry_count_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_first_ff  <= FIRST_PAGE_RST;
         cfg_stride_ff <= STRIDE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FIRST_PAGE: cfg_first_ff  <= csr_wdata[PAGE_W-1:0];
            CSR_STRIDE:     cfg_stride_ff <= csr_wdata[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // captured item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_opcode;
         pa_ff <= req_pos_a;
         pb_ff <= req_pos_b;
      end
   end

   // index counter and entry count
   always_comb begin
      case (cmd.idx_op)
         IX_ZERO: idx_in = '0;
         IX_INC:  idx_in = idx_ff + 1'b1;
         IX_PA:   idx_in = COUNT_W'(pa_ff);
         default: idx_in = idx_ff;
      endcase
      case (cmd.cnt_op)
         CN_INC:  count_in = count_ff + 1'b1;
         CN_DEC:  count_in = count_ff - 1'b1;
         CN_CLR:  count_in = '0;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         count_ff <= count_in;
         pend_ff  <= cmd.shift_rd;
      end
   end

   // used map
   always_comb begin
      used_we    = 1'b0;
      used_waddr = idx_ff[SLOT_W-1:0];
      used_wdata = 1'b0;
      case (cmd.uw_op)
         UW_SWEEP: used_we = 1'b1;
         UW_SET: begin
            used_we    = 1'b1;
            used_waddr = scan_addr_ff;
            used_wdata = 1'b1;
         end
         UW_FREE: begin
            used_we    = 1'b1;
            used_waddr = list_rdata_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_map_ff[used_waddr] <= used_wdata;
      end
      if (cmd.used_rd) begin
         used_rdata_ff <= used_map_ff[idx_ff[SLOT_W-1:0]];
         scan_addr_ff  <= idx_ff[SLOT_W-1:0];
      end
   end

   // slot list; a shift write lands in the cycle after its read
   always_comb begin
      case (cmd.lr_sel)
         LR_PB:   list_raddr = pb_ff[SLOT_W-1:0];
         LR_IDX:  list_raddr = idx_ff[SLOT_W-1:0];
         default: list_raddr = pa_ff[SLOT_W-1:0];
      endcase
      list_we    = 1'b0;
      list_waddr = list_addr_ff - 1'b1;
      list_wdata = list_rdata_ff;
      if (pend_ff) begin
         list_we = 1'b1;
      end else begin
         case (cmd.lw_op)
            LW_ADD: begin
               list_we    = 1'b1;
               list_waddr = count_ff[SLOT_W-1:0];
               list_wdata = scan_addr_ff;
            end
            LW_SWAP_A: begin
               list_we    = 1'b1;
               list_waddr = pa_ff[SLOT_W-1:0];
            end
            LW_SWAP_B: begin
               list_we    = 1'b1;
               list_waddr = pb_ff[SLOT_W-1:0];
               list_wdata = tmp_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         slot_list_ff[list_waddr] <= list_wdata;
      end
      list_rdata_ff <= slot_list_ff[list_raddr];
      list_addr_ff  <= list_raddr;
      if (cmd.tmp_ld) begin
         tmp_ff <= list_rdata_ff;
      end
   end

   // page of a slot, wrapping modulo the page space
   assign page_slot = (cmd.res_op == RES_SCAN) ? scan_addr_ff : list_rdata_ff;
   assign page_prod = PROD_W'(page_slot) * PROD_W'(cfg_stride_ff);
   assign page_calc = cfg_first_ff + PAGE_W'(page_prod);

   always_comb begin
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      case (cmd.res_op)
         RES_ZERO: begin
            res_status_in = STAT_OK;
            res_page_in   = '0;
         end
         RES_FULL: begin
            res_status_in = STAT_FULL;
            res_page_in   = '0;
         end
         RES_RANGE: begin
            res_status_in = STAT_RANGE;
            res_page_in   = '0;
         end
         RES_SCAN, RES_LIST: begin
            res_status_in = STAT_OK;
            res_page_in   = page_calc;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      if (cmd.rsp_ld) begin
         rsp_status_ff      <= res_status_ff;
         rsp_page_ff        <= res_page_ff;
         rsp_entry_count_ff <= ECOUNT_W'(count_ff);
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_page        = rsp_page_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   assign stat.op           = op_ff;
   assign stat.full         = (count_ff == COUNT_MAX);
   assign stat.pa_bad       = ({1'b0, pa_ff} >= (POS_W+1)'(count_ff));
   assign stat.pb_bad       = ({1'b0, pb_ff} >= (POS_W+1)'(count_ff));
   assign stat.used_free    = !used_rdata_ff;
   assign stat.idx_last     = (idx_ff[SLOT_W-1:0] == SLOT_LAST);
   assign stat.idx_le_count = (idx_ff <= count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("entry count beyond table size");

   a_shift_write_alone: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (cmd.lw_op == LW_NONE))
      else $error("shift write collides with another list write");

   a_add_not_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.lw_op == LW_ADD) |-> !stat.full)
      else $error("append into a full table");

endmodule

>>> rtl/fsrt_ctrl.sv
// ---------------------------------------------------------------------------
// fsrt_ctrl: controller of the record slot table
// Sequences the init sweep, the operations and the result hand-off.
// ---------------------------------------------------------------------------
module fsrt_ctrl import fsrt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [3:0] ST_INIT     = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_DISPATCH = 4'd2;
   localparam logic [3:0] ST_SCAN     = 4'd3;
   localparam logic [3:0] ST_ADD_WR   = 4'd4;
   localparam logic [3:0] ST_RM_FREE  = 4'd5;
   localparam logic [3:0] ST_RM_SHIFT = 4'd6;
   localparam logic [3:0] ST_GET_PG   = 4'd7;
   localparam logic [3:0] ST_SW_A     = 4'd8;
   localparam logic [3:0] ST_SW_B     = 4'd9;
   localparam logic [3:0] ST_SW_C     = 4'd10;
   localparam logic [3:0] ST_CLR      = 4'd11;
   localparam logic [3:0] ST_RESP     = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.uw_op  = UW_SWEEP;
            cmd.idx_op = IX_INC;
            if (stat.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.idx_op = IX_ZERO;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.lr_sel = LR_PA;
            case (stat.op)
               OP_ADD: begin
                  if (stat.full) begin
                     cmd.res_op = RES_FULL;
                     state_in   = ST_RESP;
                  end else begin
                     cmd.used_rd = 1'b1;
                     cmd.idx_op  = IX_INC;
                     state_in    = ST_SCAN;
                  end
               end
               OP_REMOVE: begin
                  if (stat.pa_bad) begin
                     cmd.res_op = RES_RANGE;
                     state_in   = ST_RESP;
                  end else begin
                     cmd.idx_op = IX_PA;
                     state_in   = ST_RM_FREE;
                  end
               end
               OP_GET: begin
                  if (stat.pa_bad) begin
                     cmd.res_op = RES_RANGE;
                     state_in   = ST_RESP;
                  end else begin
                     state_in = ST_GET_PG;
                  end
               end
               OP_SWAP: begin
                  if (stat.pa_bad || stat.pb_bad) begin
                     cmd.res_op = RES_RANGE;
                     state_in   = ST_RESP;
                  end else begin
                     state_in = ST_SW_A;
                  end
               end
               OP_CLEAR: begin
                  cmd.cnt_op = CN_CLR;
                  state_in   = ST_CLR;
               end
               default: begin
                  cmd.res_op = RES_ZERO;
                  state_in   = ST_RESP;
               end
            endcase
         end
         ST_SCAN: begin
            if (stat.used_free) begin
               state_in = ST_ADD_WR;
            end else begin
               cmd.used_rd = 1'b1;
               cmd.idx_op  = IX_INC;
            end
         end
         ST_ADD_WR: begin
            cmd.uw_op  = UW_SET;
            cmd.lw_op  = LW_ADD;
            cmd.cnt_op = CN_INC;
            cmd.res_op = RES_SCAN;
            state_in   = ST_RESP;
         end
         ST_RM_FREE: begin
            cmd.uw_op  = UW_FREE;
            cmd.cnt_op = CN_DEC;
            cmd.idx_op = IX_INC;
            cmd.res_op = RES_ZERO;
            state_in   = ST_RM_SHIFT;
         end
         ST_RM_SHIFT: begin
            if (stat.idx_le_count) begin
               cmd.lr_sel   = LR_IDX;
               cmd.idx_op   = IX_INC;
               cmd.shift_rd = 1'b1;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_GET_PG: begin
            cmd.res_op = RES_LIST;
            state_in   = ST_RESP;
         end
         ST_SW_A: begin
            cmd.tmp_ld = 1'b1;
            cmd.lr_sel = LR_PB;
            state_in   = ST_SW_B;
         end
         ST_SW_B: begin
            cmd.lw_op = LW_SWAP_A;
            state_in  = ST_SW_C;
         end
         ST_SW_C: begin
            cmd.lw_op  = LW_SWAP_B;
            cmd.res_op = RES_ZERO;
            state_in   = ST_RESP;
         end
         ST_CLR: begin
            cmd.uw_op  = UW_SWEEP;
            cmd.idx_op = IX_INC;
            if (stat.idx_last) begin
               cmd.res_op = RES_ZERO;
               state_in   = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_ld = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      if (cmd.rsp_ld) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous item still in work");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_ld |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register loaded while held");

   a_init_busy: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("request taken before the init sweep");

endmodule

>>> rtl/flash_record_slot_table.sv
// ---------------------------------------------------------------------------
// flash_record_slot_table: ordered table of flash record slots
// Keeps a list of allocated record slots with an entry count; add, remove,
// get, swap and clear operations; a used map tracks the held slots.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_opcode, req_pos_a, req_pos_b
//  rsp      out        rsp_valid/rsp_stall   rsp_status, rsp_page, rsp_entry_count
//  csr      in         csr_wr_en             csr_index, csr_wdata
//
// One item in work at a time; the used map does at most one access a cycle, the
// slot list at most a read and a write. Add scans the used map up to the lowest
// free slot, remove shifts down the entries after the removed one, clear sweeps the used map.
// The block is idle again, ready for the next item, in the same cycle that the result is posted.
// Reset sweeps the used map clear, with req_stall high until every slot is swept.
// A held result does not block the next item; only a new result waits on rsp_stall.
//
module flash_record_slot_table import fsrt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [POS_W-1:0]      req_pos_a,
   input  logic [POS_W-1:0]      req_pos_b,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [PAGE_W-1:0]     rsp_page,
   output logic [ECOUNT_W-1:0]   rsp_entry_count,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // command bundle from the controller, status bundle back from the datapath
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencing: init sweep, operation steps, result hand-off
   fsrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, counters, page arithmetic and result payload
   fsrt_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_pos_a       (req_pos_a),
      .req_pos_b       (req_pos_b),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_page        (rsp_page),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
